### sv/eeh_pkg.sv
package eeh_pkg;

   localparam int TOTAL_W     = 24;
   localparam int WIDTH_W     = 16;
   localparam int USED_W      = 10;
   localparam int FIELD_W     = 24;
   localparam int SEL_W       = 9;
   localparam int ENERGY_W    = 17;
   localparam int DIV_CNT_W   = $clog2(TOTAL_W);
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX       = '1;
   localparam logic [WIDTH_W-1:0] BIN_WIDTH_RESET = 16'd160;
   localparam logic [USED_W-1:0]  BINS_USED_RESET = 10'd307;

   localparam logic [CSR_INDEX_W-1:0] CSR_BIN_WIDTH   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BINS_IN_USE = 1'b1;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_READ   = 1'b1;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

### sv/eeh_divider.sv
module eeh_divider (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [eeh_pkg::TOTAL_W-1:0]       dividend,
   input  logic [eeh_pkg::WIDTH_W-1:0]       divisor,
   output eeh_pkg::div_status_type           status,
   output logic [eeh_pkg::TOTAL_W-1:0]       quotient
);

   logic                              busy_ff;
   logic                              done_ff;
   logic [eeh_pkg::DIV_CNT_W-1:0]     cnt_ff;
   logic [eeh_pkg::WIDTH_W-1:0]       rem_ff;
   logic [eeh_pkg::WIDTH_W-1:0]       div_ff;
   logic [eeh_pkg::TOTAL_W-1:0]       quo_ff;

   logic [eeh_pkg::WIDTH_W:0]         rem_shift;
   logic [eeh_pkg::WIDTH_W:0]         rem_diff;
   logic                              fits;
   logic [eeh_pkg::WIDTH_W-1:0]       rem_in;

   // One quotient bit per cycle, restoring form.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[eeh_pkg::TOTAL_W-1]};
      fits      = rem_shift >= {1'b0, div_ff};
      rem_diff  = rem_shift - {1'b0, div_ff};
      rem_in    = fits ? rem_diff[eeh_pkg::WIDTH_W-1:0] : rem_shift[eeh_pkg::WIDTH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= eeh_pkg::DIV_CNT_W'(eeh_pkg::TOTAL_W - 1);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         div_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[eeh_pkg::TOTAL_W-2:0], fits};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

### sv/eeh_bin_store.sv
module eeh_bin_store #(
   parameter  int NUM_BINS    = 512,
   parameter  int COUNT_WIDTH = 24,
   localparam int BIN_W       = $clog2(NUM_BINS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [BIN_W-1:0]       rd_addr,
   output logic [COUNT_WIDTH-1:0] rd_data,
   input  logic                   wr_en,
   input  logic [BIN_W-1:0]       wr_addr,
   input  logic [COUNT_WIDTH-1:0] wr_data,
   output logic                   clear_busy
);

   logic [COUNT_WIDTH-1:0] bins_ff [NUM_BINS];
   logic [COUNT_WIDTH-1:0] rd_data_ff;
   logic                   clr_busy_ff;
   logic [BIN_W-1:0]       clr_addr_ff;

   // After reset every bin is written with zero, one per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == BIN_W'(NUM_BINS - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= bins_ff[rd_addr];
      if (clr_busy_ff) begin
         bins_ff[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         bins_ff[wr_addr] <= wr_data;
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

### sv/event_energy_histogram.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  mode, cell_energy, last_cell, bin_select
// rsp_      out        rsp_valid / rsp_stall  one result item per request item
// csr_      in         csr_wr_en              csr_index, csr_wdata
//
// A cell sample without last_cell goes to the output register, or to the pending one
// while that is stalled. A read goes through the histogram memory port. A sample with
// last_cell waits for the one-bit-per-cycle divider. After reset the histogram memory
// is cleared before the first item is taken. Reset is synchronous and active high.
// A stalled result waits in the output register while the next item is taken.
module event_energy_histogram #(
   parameter int NUM_BINS    = 512,
   parameter int COUNT_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_mode,
   input  logic signed [eeh_pkg::ENERGY_W-1:0]   req_cell_energy,
   input  logic                                  req_last_cell,
   input  logic [eeh_pkg::SEL_W-1:0]             req_bin_select,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_cell_active,
   output logic                                  rsp_event_done,
   output logic [eeh_pkg::FIELD_W-1:0]           rsp_event_total,
   output logic [eeh_pkg::SEL_W-1:0]             rsp_event_bin,
   output logic                                  rsp_bin_overflow,
   output logic [eeh_pkg::FIELD_W-1:0]           rsp_bin_count,
   output logic [eeh_pkg::FIELD_W-1:0]           rsp_cumulative_count,
   output logic [eeh_pkg::FIELD_W-1:0]           rsp_events_seen,
   input  logic                                  csr_wr_en,
   input  logic [eeh_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [eeh_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int BIN_W = $clog2(NUM_BINS);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_DIV   = 6'b000100,
      ST_RD    = 6'b001000,
      ST_OUT   = 6'b010000,
      ST_SPARE = 6'b100000
   } state_type;

   typedef struct packed {
      logic                          cell_active;
      logic                          event_done;
      logic [eeh_pkg::FIELD_W-1:0]   event_total;
      logic [eeh_pkg::SEL_W-1:0]     event_bin;
      logic                          bin_overflow;
      logic [eeh_pkg::FIELD_W-1:0]   bin_count;
      logic [eeh_pkg::FIELD_W-1:0]   cumulative_count;
      logic [eeh_pkg::FIELD_W-1:0]   events_seen;
   } rsp_type;

   state_type                        state_ff, state_in;
   rsp_type                          rsp_ff, pend_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [eeh_pkg::TOTAL_W-1:0]      running_total_ff, running_total_in;
   logic [COUNT_WIDTH-1:0]           event_counter_ff, event_counter_in;
   logic [COUNT_WIDTH-1:0]           cumul_ff, cumul_in;
   logic [eeh_pkg::WIDTH_W-1:0]      bin_width_ff;
   logic [eeh_pkg::USED_W-1:0]       bins_used_ff;
   logic [eeh_pkg::TOTAL_W-1:0]      evt_total_ff;
   logic                             evt_active_ff;
   logic [BIN_W-1:0]                 evt_bin_ff;
   logic                             evt_ovf_ff;
   logic                             sel_hit_ff;
   logic                             sel_zero_ff;
   logic                             is_event_ff;

   logic                             accept;
   logic                             rsp_free;
   logic                             positive;
   logic [eeh_pkg::TOTAL_W:0]        add_sum;
   logic [eeh_pkg::TOTAL_W-1:0]      new_total;
   logic                             div_start;
   logic [eeh_pkg::WIDTH_W-1:0]      divisor;
   eeh_pkg::div_status_type          div_status;
   logic [eeh_pkg::TOTAL_W-1:0]      quotient;
   logic [eeh_pkg::USED_W-1:0]       used_m1;
   logic [31:0]                      used_m1_ext;
   logic [BIN_W-1:0]                 last_bin;
   logic                             ovf_calc;
   logic [BIN_W-1:0]                 bin_calc;
   logic [31:0]                      sel_ext;
   logic [BIN_W-1:0]                 rd_addr;
   logic [COUNT_WIDTH-1:0]           rd_data;
   logic                             clear_busy;
   logic                             mem_wr_en;
   logic [COUNT_WIDTH-1:0]           cnt_inc;
   logic [COUNT_WIDTH-1:0]           sel_cnt;
   logic [COUNT_WIDTH:0]             cum_sum;
   logic [31:0]                      evc_ext;
   logic [31:0]                      evc_inc_ext;
   logic [31:0]                      sel_cnt_ext;
   logic [31:0]                      cum_ext;
   logic [31:0]                      bin_ext;
   rsp_type                          sample_rsp;
   rsp_type                          done_rsp;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // Cell sample path.
   always_comb begin
      positive  = (req_cell_energy != '0) && !req_cell_energy[eeh_pkg::ENERGY_W-1];
      add_sum   = {1'b0, running_total_ff}
                + (eeh_pkg::TOTAL_W + 1)'(req_cell_energy[eeh_pkg::ENERGY_W-2:0]);
      if (!positive) begin
         new_total = running_total_ff;
      end else if (add_sum[eeh_pkg::TOTAL_W]) begin
         new_total = eeh_pkg::TOTAL_MAX;
      end else begin
         new_total = add_sum[eeh_pkg::TOTAL_W-1:0];
      end
      div_start = accept && (req_mode == eeh_pkg::MODE_SAMPLE) && req_last_cell;
      divisor   = (bin_width_ff == '0) ? eeh_pkg::WIDTH_W'(1) : bin_width_ff;
   end

   eeh_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (new_total),
      .divisor  (divisor),
      .status   (div_status),
      .quotient (quotient)
   );

   // Bin selection from the quotient, clamped to the last bin in use.
   always_comb begin
      used_m1     = bins_used_ff - eeh_pkg::USED_W'(1);
      used_m1_ext = 32'(used_m1);
      if (bins_used_ff == '0) begin
         last_bin = '0;
      end else if (32'(bins_used_ff) > 32'(NUM_BINS)) begin
         last_bin = BIN_W'(NUM_BINS - 1);
      end else begin
         last_bin = used_m1_ext[BIN_W-1:0];
      end
      ovf_calc = quotient > eeh_pkg::TOTAL_W'(last_bin);
      bin_calc = ovf_calc ? last_bin : quotient[BIN_W-1:0];
      sel_ext  = 32'(req_bin_select);
      rd_addr  = (state_ff == ST_IDLE) ? sel_ext[BIN_W-1:0] : bin_calc;
   end

   // The memory is written only in ST_RD and read again no earlier than the next
   // accepted item, so a read never overlaps a pending write to the same bin.
   eeh_bin_store #(
      .NUM_BINS    (NUM_BINS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_bin_store (
      .clock      (clock),
      .reset      (reset),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .wr_en      (mem_wr_en),
      .wr_addr    (evt_bin_ff),
      .wr_data    (cnt_inc),
      .clear_busy (clear_busy)
   );

   always_comb begin
      mem_wr_en        = (state_ff == ST_RD) && is_event_ff;
      cnt_inc          = (rd_data == '1) ? rd_data : rd_data + 1'b1;
      event_counter_in = (event_counter_ff == '1) ? event_counter_ff
                                                  : event_counter_ff + 1'b1;
      sel_cnt          = sel_hit_ff ? rd_data : '0;
      cum_sum          = {1'b0, cumul_ff} + {1'b0, sel_cnt};
      if (sel_zero_ff) begin
         cumul_in = sel_cnt;
      end else if (cum_sum[COUNT_WIDTH]) begin
         cumul_in = '1;
      end else begin
         cumul_in = cum_sum[COUNT_WIDTH-1:0];
      end
      evc_ext     = 32'(event_counter_ff);
      evc_inc_ext = 32'(event_counter_in);
      sel_cnt_ext = 32'(sel_cnt);
      cum_ext     = 32'(cumul_in);
      bin_ext     = 32'(evt_bin_ff);
   end

   always_comb begin
      sample_rsp             = '0;
      sample_rsp.cell_active = positive;
      sample_rsp.event_total = new_total;
      sample_rsp.events_seen = evc_ext[eeh_pkg::FIELD_W-1:0];

      done_rsp = '0;
      if (is_event_ff) begin
         done_rsp.cell_active  = evt_active_ff;
         done_rsp.event_done   = 1'b1;
         done_rsp.event_total  = evt_total_ff;
         done_rsp.event_bin    = bin_ext[eeh_pkg::SEL_W-1:0];
         done_rsp.bin_overflow = evt_ovf_ff;
         done_rsp.events_seen  = evc_inc_ext[eeh_pkg::FIELD_W-1:0];
      end else begin
         done_rsp.bin_count        = sel_cnt_ext[eeh_pkg::FIELD_W-1:0];
         done_rsp.cumulative_count = cum_ext[eeh_pkg::FIELD_W-1:0];
         done_rsp.events_seen      = evc_ext[eeh_pkg::FIELD_W-1:0];
      end
   end

   always_comb begin
      state_in         = state_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      running_total_in = running_total_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (!clear_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == eeh_pkg::MODE_READ) begin
                  state_in = ST_RD;
               end else if (req_last_cell) begin
                  running_total_in = '0;
                  state_in         = ST_DIV;
               end else begin
                  running_total_in = new_total;
                  if (rsp_free) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     state_in = ST_OUT;
                  end
               end
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               state_in = ST_RD;
            end
         end
         ST_RD: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         rsp_valid_ff     <= 1'b0;
         running_total_ff <= '0;
         event_counter_ff <= '0;
         cumul_ff         <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         running_total_ff <= running_total_in;
         if (mem_wr_en) begin
            event_counter_ff <= event_counter_in;
         end
         if ((state_ff == ST_RD) && !is_event_ff) begin
            cumul_ff <= cumul_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_width_ff <= eeh_pkg::BIN_WIDTH_RESET;
         bins_used_ff <= eeh_pkg::BINS_USED_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            eeh_pkg::CSR_BIN_WIDTH:   bin_width_ff <= csr_wdata;
            eeh_pkg::CSR_BINS_IN_USE: bins_used_ff <= csr_wdata[eeh_pkg::USED_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         is_event_ff   <= (req_mode == eeh_pkg::MODE_SAMPLE);
         sel_hit_ff    <= sel_ext < 32'(NUM_BINS);
         sel_zero_ff   <= (req_bin_select == '0);
         evt_total_ff  <= new_total;
         evt_active_ff <= positive;
      end
      if ((state_ff == ST_DIV) && div_status.done) begin
         evt_bin_ff <= bin_calc;
         evt_ovf_ff <= ovf_calc;
      end
      if ((state_ff == ST_IDLE) && accept && rsp_free) begin
         rsp_ff <= sample_rsp;
      end else if ((state_ff == ST_OUT) && rsp_free) begin
         rsp_ff <= pend_ff;
      end
      if ((state_ff == ST_IDLE) && accept && !rsp_free) begin
         pend_ff <= sample_rsp;
      end else if (state_ff == ST_RD) begin
         pend_ff <= done_rsp;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_cell_active      = rsp_ff.cell_active;
   assign rsp_event_done       = rsp_ff.event_done;
   assign rsp_event_total      = rsp_ff.event_total;
   assign rsp_event_bin        = rsp_ff.event_bin;
   assign rsp_bin_overflow     = rsp_ff.bin_overflow;
   assign rsp_bin_count        = rsp_ff.bin_count;
   assign rsp_cumulative_count = rsp_ff.cumulative_count;
   assign rsp_events_seen      = rsp_ff.events_seen;

`ifndef SYNTHESIS
   a_no_item_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !clear_busy)
      else $error("Item taken while the histogram is being cleared.");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("Divider finished outside the divide state.");

   a_div_runs_after_start: assert property (@(posedge clock) disable iff (reset)
      div_start |=> div_status.busy)
      else $error("Divider did not start on an event-closing item.");

   a_out_holds_when_blocked: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_OUT) && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_OUT))
      else $error("Pending item left while the output register was blocked.");
`endif

endmodule
